[rtl/solq_pkg.sv]
// Package for the search open list queue: sizes, codes, transaction structs and
// the command/status structs between the controller and the datapath.
// No dependencies; every other RTL file but solq_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package solq_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int TILE_COUNT = 9;

  localparam int BOARD_W = 36;
  localparam int LEN_W   = 8;
  localparam int HEUR_W  = 8;
  localparam int TAG_W   = 16;
  localparam int COST_W  = 9;
  localparam int ENTRY_W = BOARD_W + LEN_W + HEUR_W + TAG_W;

  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

  localparam int TILE_BITS = 4 * TILE_COUNT;
  localparam logic [BOARD_W-1:0] BOARD_MASK = (TILE_BITS >= BOARD_W) ? {BOARD_W{1'b1}} :
      ((BOARD_W'(1) << TILE_BITS) - BOARD_W'(1));

  typedef enum logic [1:0] {
    OP_ENQ       = 2'd0,
    OP_DEQ_FRONT = 2'd1,
    OP_DEQ_MIN   = 2'd2,
    OP_QUERY     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [BOARD_W-1:0] board;
    logic [LEN_W-1:0]   path_len;
    logic [HEUR_W-1:0]  heur;
    logic [TAG_W-1:0]   path_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [BOARD_W-1:0] out_board;
    logic [LEN_W-1:0]   out_path_len;
    logic [HEUR_W-1:0]  out_heur;
    logic [TAG_W-1:0]   out_path_tag;
    logic               now_empty;
  } out_item_t;

  typedef struct packed {
    logic [BOARD_W-1:0] board;
    logic [LEN_W-1:0]   path_len;
    logic [HEUR_W-1:0]  heur;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic take;
    logic scan_en;
    logic shift_start;
    logic shift_en;
    logic shift_end;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_e  in_op;
    op_e  op;
    logic empty;
    logic scan_done;
    logic shift_done;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

[rtl/search_open_list_queue_core.sv]
// Top level of the search open list queue: controller plus datapath.
// Depends on solq_pkg, solq_ctrl, solq_dp (which holds solq_ram).
`timescale 1ns / 1ps
`default_nettype none

// The block keeps up to LIST_DEPTH entries in arrival order in one memory and
// handles one transaction at a time; a finished result sits in an output
// register, so the next transaction is accepted while it waits. An enqueue goes
// straight from acceptance to the response. A query reads every stored entry,
// one per cycle through the memory read port. A dequeue reads the candidates
// the same way (only the oldest entry for dequeue-front, all of them for
// dequeue-min) and then closes the gap by moving every later entry down one
// place, one per cycle. Any removal or query on an empty list, and an enqueue
// into a full list, also goes straight to the response.
module search_open_list_queue_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire solq_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output solq_pkg::out_item_t      out_data_o
);

  import solq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  solq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  solq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

  // After a transaction is accepted the block stalls its input in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  // The controller drives at most one phase at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.take, cmd.scan_en, cmd.shift_en, cmd.load_out}))
    else $error("controller phases overlap");

  // A result is loaded only when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_o && out_stall_i))
    else $error("result loaded over a held transaction");

  // A loaded result is presented in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

[rtl/solq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module solq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                   wdata_i,
  input  wire logic                               re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                   rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/solq_ctrl.sv]
// Controller state machine of the open list queue: sequences scan, shift and response.
// Depends on solq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module solq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire solq_pkg::sts_t sts_i,
  output solq_pkg::cmd_t     cmd_o
);

  import solq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.in_op == OP_ENQ || sts_i.empty) begin
            state_d = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.op == OP_QUERY) begin
            state_d = S_RESP;
          end else begin
            cmd_o.shift_start = 1'b1;
            state_d = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        cmd_o.shift_en = 1'b1;
        if (sts_i.shift_done) begin
          cmd_o.shift_end = 1'b1;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/solq_dp.sv]
// Datapath of the open list queue: entry memory, fill count, scan compare,
// compaction after a removal and the output register. Depends on solq_pkg, solq_ram.
`timescale 1ns / 1ps
`default_nettype none

module solq_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire solq_pkg::in_item_t in_data_i,
  input  wire solq_pkg::cmd_t     cmd_i,
  output solq_pkg::sts_t          sts_o,
  output logic                    out_valid_o,
  output solq_pkg::out_item_t     out_data_o,
  input  wire logic               out_stall_i
);

  import solq_pkg::*;

  entry_t            rd_entry;
  entry_t            wr_entry;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;

  op_e                op_q;
  logic [BOARD_W-1:0] board_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   len_q;
  logic [CNT_W-1:0]   idx_q;
  logic               pend_q;
  logic [ADDR_W-1:0]  pend_idx_q;
  logic [COST_W-1:0]  best_cost_q;
  logic [ADDR_W-1:0]  best_idx_q;
  logic [ADDR_W-1:0]  best_idx_d;
  entry_t             best_q;
  logic               found_q;
  logic               removed_q;
  status_e            status_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic              enq_ok;
  logic              scan_issue;
  logic              shift_issue;
  logic              issue;
  logic              scan_hit;
  logic              take_best;
  logic              match;
  logic [COST_W-1:0] cur_cost;
  out_item_t         res;

  assign enq_ok = cmd_i.take && (in_data_i.operation == OP_ENQ) &&
                  (count_q < CNT_W'(LIST_DEPTH));
  assign scan_issue  = cmd_i.scan_en && (idx_q < len_q);
  assign shift_issue = cmd_i.shift_en && (idx_q < count_q);
  assign issue       = scan_issue || shift_issue;

  assign cur_cost  = COST_W'(rd_entry.path_len) + COST_W'(rd_entry.heur);
  assign scan_hit  = cmd_i.scan_en && pend_q;
  assign take_best = scan_hit && ((pend_idx_q == '0) || (cur_cost < best_cost_q));
  assign best_idx_d = take_best ? pend_idx_q : best_idx_q;
  assign match = scan_hit && (op_q == OP_QUERY) &&
                 (((rd_entry.board ^ board_q) & BOARD_MASK) == '0);

  assign ram_we    = enq_ok || (cmd_i.shift_en && pend_q);
  assign ram_waddr = cmd_i.shift_en ? (pend_idx_q - ADDR_W'(1)) : count_q[ADDR_W-1:0];
  assign wr_entry  = cmd_i.shift_en ? rd_entry :
                     {in_data_i.board, in_data_i.path_len, in_data_i.heur, in_data_i.path_tag};

  solq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(LIST_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_entry),
    .re_i   (issue),
    .raddr_i(idx_q[ADDR_W-1:0]),
    .rdata_o(rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_ENQ;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= issue;
      if (cmd_i.take) begin
        op_q <= op_e'(in_data_i.operation);
      end
      if (enq_ok) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.shift_end) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= idx_q[ADDR_W-1:0];
    if (cmd_i.take) begin
      board_q   <= in_data_i.board;
      len_q     <= (in_data_i.operation == OP_DEQ_FRONT) ? CNT_W'(1) : count_q;
      idx_q     <= '0;
      found_q   <= 1'b0;
      removed_q <= 1'b0;
      case (op_e'(in_data_i.operation))
        OP_ENQ:       status_q <= (count_q < CNT_W'(LIST_DEPTH)) ? STAT_DONE : STAT_FULL;
        OP_DEQ_FRONT: status_q <= (count_q == '0) ? STAT_EMPTY : STAT_DONE;
        OP_DEQ_MIN:   status_q <= (count_q == '0) ? STAT_EMPTY : STAT_DONE;
        default:      status_q <= STAT_DONE;
      endcase
    end else if (cmd_i.shift_start) begin
      idx_q     <= CNT_W'(best_idx_d) + CNT_W'(1);
      removed_q <= 1'b1;
    end else if (issue) begin
      idx_q <= idx_q + CNT_W'(1);
    end
    if (take_best) begin
      best_cost_q <= cur_cost;
      best_idx_q  <= pend_idx_q;
      best_q      <= rd_entry;
    end
    if (match) begin
      found_q <= 1'b1;
    end
    if (cmd_i.load_out) begin
      out_q <= res;
    end
  end

  always_comb begin
    res              = '0;
    res.status       = status_q;
    res.found        = found_q;
    res.now_empty    = (count_q == '0);
    if (removed_q) begin
      res.out_board    = best_q.board;
      res.out_path_len = best_q.path_len;
      res.out_heur     = best_q.heur;
      res.out_path_tag = best_q.tag;
    end
  end

  assign sts_o.in_op      = op_e'(in_data_i.operation);
  assign sts_o.op         = op_q;
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.scan_done  = scan_hit && ((CNT_W'(pend_idx_q) + CNT_W'(1)) == len_q);
  assign sts_o.shift_done = !(idx_q < count_q) && !pend_q;
  assign sts_o.out_busy   = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
